// File: hdl/slir_pkg.sv
package slir_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VAL_W = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic ins;
    logic rem;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } flags_t;

endpackage

// File: hdl/slir_cell.sv
module slir_cell import slir_pkg::*; (
  input  logic                    clk,
  input  cmd_t                    cmd,
  input  logic                    occupied,
  input  logic                    at_tail,
  input  logic                    left_gt,
  input  logic signed [VAL_W-1:0] left_entry,
  input  logic signed [VAL_W-1:0] right_entry,
  output logic signed [VAL_W-1:0] entry,
  output flags_t                  flags
);

  logic ge;

  assign flags.gt = occupied && (entry > cmd.value);
  assign flags.eq = occupied && (entry == cmd.value);
  assign ge = occupied && (entry >= cmd.value);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (left_gt) begin
        entry <= left_entry;
      end else if (flags.gt || at_tail) begin
        entry <= cmd.value;
      end
    end else if (cmd.rem && ge) begin
      entry <= right_entry;
    end
  end

endmodule

// File: hdl/sorted_list_insert_remove.sv
// Sorted table of signed 32-bit values, insert and remove.
//
// Input channel: op, value with in_valid / in_ready. op 0 inserts value after
// any equal entries; op 1 removes the lowest entry equal to value.
// Output channel: status, count, is_empty with out_valid / out_ready. Every
// request yields exactly one result: status 0 done, 1 insert refused because
// the table is full, 2 remove refused because no entry equals value.
//
// The result of a request is registered at the edge that accepts it. Throughput
// is one request per cycle while the output is not stalled; all cells of the
// chain compare against the request value at once and shift toward or away
// from their neighbor in the same edge.
//
// When the receiver stalls, the result holds in the output register and
// in_ready drops until it is taken; in_ready is high whenever the output
// register is empty or being emptied in the same cycle.
//
// Reset (rst, synchronous) empties the table and the output register.
module sorted_list_insert_remove import slir_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    op,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic [4:0]              count,
  output logic                    is_empty
);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [1:0] status_next;
  logic accept;
  logic full;
  logic found;
  cmd_t cmd;
  logic signed [VAL_W-1:0] entry [CAPACITY];
  flags_t flags [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign full = (cnt == CNT_W'(CAPACITY));

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      eq_vec[i] = flags[i].eq;
    end
  end

  assign found = |eq_vec;

  assign cmd.value = value;
  assign cmd.ins = accept && (op == OP_INSERT) && !full;
  assign cmd.rem = accept && (op == OP_REMOVE) && found;

  always_comb begin
    cnt_next = cnt;
    status_next = ST_DONE;
    if (op == OP_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        cnt_next = cnt + CNT_W'(1);
      end
    end else begin
      if (!found) begin
        status_next = ST_NOT_FOUND;
      end else begin
        cnt_next = cnt - CNT_W'(1);
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic left_gt;
    logic signed [VAL_W-1:0] left_entry;
    logic signed [VAL_W-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_gt = 1'b0;
      assign left_entry = value;
    end else begin : g_left
      assign left_gt = flags[i-1].gt;
      assign left_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = value;
    end else begin : g_right
      assign right_entry = entry[i+1];
    end

    slir_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (CNT_W'(i) < cnt),
      .at_tail     (CNT_W'(i) == cnt),
      .left_gt     (left_gt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry[i]),
      .flags       (flags[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt <= cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      count <= 5'(cnt_next);
      is_empty <= (cnt_next == '0);
    end
  end

endmodule

// File: hdl/slir_checker.sv
module slir_checker import slir_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [4:0] count,
  input logic       is_empty
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == 5'd0)))
    else $error("empty flag disagrees with count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (count == 5'(CAPACITY)))
    else $error("full status with table not at capacity");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_DONE || status == ST_FULL || status == ST_NOT_FOUND))
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(count)))
    else $error("stalled result changed");

endmodule

bind sorted_list_insert_remove slir_checker u_slir_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .count     (count),
  .is_empty  (is_empty)
);

// File: sim/tb_sorted_list_insert_remove.sv
module tb_sorted_list_insert_remove;
  timeunit 1ns;
  timeprecision 1ps;

  import slir_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int HOLDOFF_LEN  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] count;
    logic       is_empty;
  } result_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    op = OP_INSERT;
  logic signed [VAL_W-1:0] value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              status;
  logic [4:0]              count;
  logic                    is_empty;

  logic signed [VAL_W-1:0] held_values[$];
  result_t                 pending_results[$];

  int tx_idle_pct;
  int rx_stall_pct;
  int holdoff_left;
  int mismatches;
  int idle_cycles;
  int n_inserted;
  int n_removed;
  int n_full_refused;
  int n_not_found;
  int n_results;

  sorted_list_insert_remove dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .count    (count),
    .is_empty (is_empty)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Apply one request to the sorted table copy and return its result.
  function automatic result_t predict_outcome(logic req_op, logic signed [VAL_W-1:0] v);
    result_t r;
    int pos;
    pos = 0;
    r.status = ST_DONE;
    if (req_op == OP_INSERT) begin
      if (held_values.size() >= CAPACITY) begin
        r.status = ST_FULL;
        n_full_refused++;
      end else begin
        while (pos < held_values.size() && held_values[pos] <= v) pos++;
        held_values.insert(pos, v);
        n_inserted++;
      end
    end else begin
      while (pos < held_values.size() && held_values[pos] != v) pos++;
      if (pos >= held_values.size()) begin
        r.status = ST_NOT_FOUND;
        n_not_found++;
      end else begin
        held_values.delete(pos);
        n_removed++;
      end
    end
    r.count = 5'(held_values.size());
    r.is_empty = (held_values.size() == 0);
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return VAL_W'($urandom);
      1: begin
        case ($urandom_range(5))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh8000_0001;
          3: return 32'sh7fff_fffe;
          4: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return VAL_W'(int'($urandom_range(15)) - 8);
    endcase
  endfunction

  task automatic send_request(logic req_op, logic signed [VAL_W-1:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= req_op;
    value <= v;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_outcome(req_op, v));
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_extremes();
    send_request(OP_REMOVE, 32'sd0);
    send_request(OP_INSERT, 32'sh7fff_ffff);
    send_request(OP_INSERT, 32'sh8000_0000);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_REMOVE, 32'sd0);
    send_request(OP_REMOVE, 32'sd12345);
    send_request(OP_REMOVE, 32'sh8000_0000);
    send_request(OP_REMOVE, 32'sh7fff_ffff);
  endtask

  task automatic test_full_table();
    while (held_values.size() < CAPACITY)
      send_request(OP_INSERT, VAL_W'(int'($urandom_range(5)) - 2));
    send_request(OP_INSERT, 32'sd7);
  endtask

  task automatic test_random_mix(int n_items, int tx_pct, int rx_pct);
    bit rising;
    int ins_pct;
    logic req_op;
    logic signed [VAL_W-1:0] v;
    rising = 1'b1;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (n_items) begin
      if (held_values.size() >= CAPACITY && $urandom_range(3) == 0) rising = 1'b0;
      if (held_values.size() == 0 && $urandom_range(3) == 0) rising = 1'b1;
      ins_pct = rising ? 70 : 30;
      req_op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
      if (req_op == OP_REMOVE && held_values.size() != 0 && $urandom_range(3) != 0)
        v = held_values[$urandom_range(held_values.size() - 1)];
      else
        v = pick_value();
      send_request(req_op, v);
    end
  endtask

  task automatic test_output_holdoff();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    holdoff_left = HOLDOFF_LEN;
    repeat (20) send_request($urandom_range(1) ? OP_REMOVE : OP_INSERT, pick_value());
  endtask

  task automatic test_drain_pause();
    tx_idle_pct = 18;
    rx_stall_pct = 18;
    repeat (10) send_request(OP_INSERT, pick_value());
    wait_until_drained();
    repeat (10) send_request(OP_REMOVE, pick_value());
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d count %0d is_empty %0d",
                 status, count, is_empty);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, count);
            mismatches++;
          end
          if (is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", want.is_empty, is_empty);
            mismatches++;
          end
        end
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d cycles without progress", idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    test_full_table();
    test_random_mix(270, 0, 0);
    test_output_holdoff();
    test_random_mix(270, 88, 0);
    test_drain_pause();
    test_random_mix(270, 0, 88);
    test_random_mix(270, 18, 18);

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Checked %0d results: %0d inserts, %0d removes, %0d refused on full table,",
             n_results, n_inserted, n_removed, n_full_refused);
    $display("%0d removes of absent values, under idle, stall and long holdoff traffic",
             n_not_found);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
